// ===== hdl/swmax_pkg.sv =====
// ----------------------------------------------------------------------------
// swmax_pkg
// Shared constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swmax_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

    // power of two, so the pointers wrap on their own
    localparam int FIFO_DEPTH = 2;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming maximum over the last window_size samples of each array.
// Each sample beat passes through the input queue and the registered result
// stage. Throughput: one sample per cycle, set by the parallel update of the
// candidate cell row, unless the result is held or expired head candidates
// from a lowered window_size are dropped. Reset (synchronous, active low)
// clears the queue, the array position and sets window_size to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum import swmax_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int DW          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,   // window_size
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [DW-1:0]    s_axis_tdata,  // sample
    input  wire logic             s_axis_tlast,  // end_of_array
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [DW-1:0]         m_axis_tdata,  // window_max
    output logic                  m_axis_tlast,  // final_result
    output logic                  m_axis_tuser   // partial_window
);

    localparam int IW = SAMPLE_WIDTH + 1;

    logic [CFG_W-1:0]        r_window_size;
    logic                    w_q_valid;
    logic                    w_q_ready;
    logic [IW-1:0]           w_q_data;
    logic [SAMPLE_WIDTH-1:0] w_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_window_size <= i_cfg_data;
        end
    end

    swmax_front #(
        .DATA_W (IW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  ({s_axis_tlast, s_axis_tdata[SAMPLE_WIDTH-1:0]}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    swmax_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_ready       (w_q_ready),
        .i_sample      (w_q_data[SAMPLE_WIDTH-1:0]),
        .i_last        (w_q_data[SAMPLE_WIDTH]),
        .i_window_size (r_window_size),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_window_max  (w_max),
        .o_final       (m_axis_tlast),
        .o_partial     (m_axis_tuser)
    );

    assign m_axis_tdata = DW'(w_max);

endmodule

`default_nettype wire

// ===== hdl/swmax_front.sv =====
// ----------------------------------------------------------------------------
// swmax_front
// Input side: takes sample beats and holds them in a short queue until the
// window engine is free to take them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swmax_front import swmax_pkg::*; #(
    parameter int DATA_W = SAMPLE_WIDTH_DEF + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_data
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_cnt != (AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swmax_back.sv =====
// ----------------------------------------------------------------------------
// swmax_back
// Window engine: a row of candidate cells, decreasing in value from the head,
// updated in parallel per sample, with a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swmax_back import swmax_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                    i_last,
    input  wire logic [CFG_W-1:0]        i_window_size,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0]      o_window_max,
    output logic                         o_final,
    output logic                         o_partial
);

    localparam int N       = WINDOW_MAX;
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int PW      = $clog2(POS_MOD);
    localparam int CW      = (PW > CFG_W) ? PW : CFG_W;

    logic signed [SAMPLE_WIDTH-1:0] r_val [N];
    logic [PW-1:0]                  r_qpos [N];
    logic [N-1:0]                   r_vld;
    logic [PW-1:0]                  r_pos;
    logic                           r_filled;

    logic signed [SAMPLE_WIDTH-1:0] v_val [N];
    logic [PW-1:0]                  v_qpos [N];
    logic [N-1:0]                   v_vld;
    logic signed [SAMPLE_WIDTH-1:0] n_val [N];
    logic [PW-1:0]                  n_qpos [N];
    logic [N-1:0]                   n_vld;
    logic [N-1:0]                   w_stale;
    logic [N-1:0]                   w_keep;

    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_max;
    logic                           r_out_last;
    logic                           r_out_part;

    logic signed [SAMPLE_WIDTH-1:0] w_x;
    logic [CW-1:0]                  w_ws;
    logic [CW-1:0]                  w_k;
    logic [PW-1:0]                  n_pos;
    logic                           n_filled;
    logic                           w_out_free;
    logic                           w_shift_only;
    logic                           w_take_item;

    assign w_x = $signed(i_sample);

    always_comb begin
        w_ws = CW'(i_window_size);
        if (w_ws == '0) begin
            w_k = CW'(1);
        end else if (w_ws > CW'(WINDOW_MAX)) begin
            w_k = CW'(WINDOW_MAX);
        end else begin
            w_k = w_ws;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic [PW:0] w_diff;

            always_comb begin
                w_diff = {1'b0, r_pos} - {1'b0, r_qpos[gi]};
                if (r_pos < r_qpos[gi]) begin
                    w_diff = w_diff + (PW+1)'(POS_MOD);
                end
            end

            assign w_stale[gi] = r_vld[gi] && (CW'(w_diff[PW-1:0]) >= w_k);

            if (gi < N - 1) begin : g_mid
                always_comb begin
                    if (w_stale[0]) begin
                        v_vld[gi]  = r_vld[gi+1];
                        v_val[gi]  = r_val[gi+1];
                        v_qpos[gi] = r_qpos[gi+1];
                    end else begin
                        v_vld[gi]  = r_vld[gi];
                        v_val[gi]  = r_val[gi];
                        v_qpos[gi] = r_qpos[gi];
                    end
                end
            end else begin : g_end
                always_comb begin
                    v_vld[gi]  = r_vld[gi] && !w_stale[0];
                    v_val[gi]  = r_val[gi];
                    v_qpos[gi] = r_qpos[gi];
                end
            end

            assign w_keep[gi] = v_vld[gi] && (v_val[gi] > w_x);

            if (gi == 0) begin : g_head
                assign n_vld[gi] = 1'b1;
            end else begin : g_tail
                assign n_vld[gi] = w_keep[gi] || w_keep[gi-1];
            end

            assign n_val[gi]  = w_keep[gi] ? v_val[gi] : w_x;
            assign n_qpos[gi] = w_keep[gi] ? v_qpos[gi] : r_pos;
        end
    endgenerate

    assign n_pos        = (r_pos == PW'(POS_MOD - 1)) ? '0 : r_pos + PW'(1);
    assign n_filled     = r_filled || (CW'(r_pos) >= (w_k - CW'(1)));
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_shift_only = i_valid && w_stale[1];
    assign w_take_item  = i_valid && !w_stale[1] && w_out_free;

    assign o_ready      = w_take_item;
    assign o_valid      = r_out_valid;
    assign o_window_max = r_out_max;
    assign o_final      = r_out_last;
    assign o_partial    = r_out_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_shift_only) begin
                r_vld <= v_vld;
            end else if (w_take_item) begin
                if (i_last) begin
                    r_vld    <= '0;
                    r_pos    <= '0;
                    r_filled <= 1'b0;
                end else begin
                    r_vld    <= n_vld;
                    r_pos    <= n_pos;
                    r_filled <= n_filled;
                end
            end
            if (w_take_item && (n_filled || i_last)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift_only) begin
            r_val  <= v_val;
            r_qpos <= v_qpos;
        end else if (w_take_item) begin
            r_val  <= n_val;
            r_qpos <= n_qpos;
        end
        if (w_take_item) begin
            r_out_max  <= n_val[0];
            r_out_last <= i_last;
            r_out_part <= i_last && !n_filled;
        end
    end

endmodule

`default_nettype wire
